// ===== src/zrcs_pkg.sv =====
// ----------------------------------------------------------------------------
// zrcs_pkg
// Shared types and constants of the zone read chunk splitter: request and
// result words, zone and status codes, controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package zrcs_pkg;

   localparam int MAX_BYTES_DEF = 416;
   localparam int MAX_SLOT_DEF  = 15;
   localparam int RESULT_CAP    = 20;
   localparam int CNT_W         = $clog2(RESULT_CAP);

   // Zone codes.
   localparam logic [1:0] ZONE_CONFIG  = 2'd0;
   localparam logic [1:0] ZONE_OTP     = 2'd1;
   localparam logic [1:0] ZONE_DATA    = 2'd2;
   localparam logic [1:0] ZONE_INVALID = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ZONE   = 3'd1;
   localparam logic [2:0] ST_BAD_SLOT   = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
   localparam logic [2:0] ST_NOT_LOCKED = 3'd4;
   localparam logic [2:0] ST_PAST_END   = 3'd5;

   // Register index of the lock register.
   localparam logic REG_LOCK = 1'b0;

   typedef struct packed {
      logic [1:0] zone;
      logic [4:0] slot;
      logic [8:0] start_offset;
      logic [8:0] byte_count;
      logic [8:0] zone_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       issue_read;
      logic [3:0] block_index;
      logic [2:0] word_index;
      logic       read_full_block;
      logic [4:0] buffer_start;
      logic [5:0] copy_bytes;
      logic [8:0] dest_index;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic report;
      logic split;
   } dp_cmd_type;

   typedef struct packed {
      logic reject;
      logic last;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== src/zrcs_csr.sv =====
// ----------------------------------------------------------------------------
// zrcs_csr
// APB register slave holding the data zone lock bit.
// ----------------------------------------------------------------------------
`default_nettype none

module zrcs_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic             locked
);
   import zrcs_pkg::*;

   logic locked_ff;
   logic locked_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_LOCK);

   always_comb begin
      locked_in = locked_ff;
      if (wr_en) begin
         locked_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff <= 1'b0;
      end else begin
         locked_ff <= locked_in;
      end
   end

   assign prdata = (paddr[2] == REG_LOCK) ? {31'd0, locked_ff} : 32'd0;
   assign locked = locked_ff;

endmodule

`default_nettype wire

// ===== src/zrcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// zrcs_ctrl
// Controller: takes a request, then either reports a status word or steps the
// datapath through the read command run until the last command.
// ----------------------------------------------------------------------------
`default_nettype none

module zrcs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire zrcs_pkg::dp_stat_type stat,
   output zrcs_pkg::dp_cmd_type       cmd
);
   import zrcs_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      REPORT,
      SPLIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.reject ? REPORT : SPLIT;
            end
         end
         REPORT: begin
            cmd.report = 1'b1;
            state_in   = IDLE;
         end
         SPLIT: begin
            cmd.split = 1'b1;
            if (stat.last) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/zrcs_dp.sv =====
// ----------------------------------------------------------------------------
// zrcs_dp
// Datapath: request checks, the block/word position counters and the
// registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module zrcs_dp #(
   parameter int MAX_BYTES = zrcs_pkg::MAX_BYTES_DEF,
   parameter int MAX_SLOT  = zrcs_pkg::MAX_SLOT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire zrcs_pkg::req_type    req_data,
   input  wire logic                 locked,
   input  wire zrcs_pkg::dp_cmd_type cmd,
   output zrcs_pkg::dp_stat_type     stat,
   output logic                      rsp_valid,
   output zrcs_pkg::rsp_type         rsp_data
);
   import zrcs_pkg::*;

   localparam logic [8:0] MaxBytesW = 9'(MAX_BYTES);
   localparam logic [4:0] MaxSlotW  = 5'(MAX_SLOT);

   logic [8:0]       off_ff, off_in;
   logic [8:0]       len_ff, len_in;
   logic [8:0]       zsz_ff, zsz_in;
   logic [2:0]       status_ff, status_in;
   logic [3:0]       blk_ff, blk_in;
   logic [3:0]       word_ff, word_in;
   logic [8:0]       done_ff, done_in;
   logic             wmode_ff, wmode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // Request checks, evaluated on the live request word.
   logic [8:0] zsz_sat;
   logic [9:0] req_end;
   logic [2:0] req_status;

   always_comb begin
      zsz_sat = (req_data.zone_bytes > MaxBytesW) ? MaxBytesW : req_data.zone_bytes;
      req_end = {1'b0, req_data.start_offset} + {1'b0, req_data.byte_count};
      if (req_data.zone == ZONE_INVALID) begin
         req_status = ST_BAD_ZONE;
      end else if (req_data.zone == ZONE_DATA && req_data.slot > MaxSlotW) begin
         req_status = ST_BAD_SLOT;
      end else if (req_data.byte_count > MaxBytesW || req_data.start_offset > MaxBytesW) begin
         req_status = ST_TOO_LARGE;
      end else if ((req_data.zone == ZONE_OTP || req_data.zone == ZONE_DATA) && !locked) begin
         req_status = ST_NOT_LOCKED;
      end else if (req_data.byte_count != 9'd0 && req_end > {1'b0, zsz_sat}) begin
         req_status = ST_PAST_END;
      end else begin
         req_status = ST_OK;
      end
   end

   // One read command per cycle from the current position.
   logic [9:0] blk_base;
   logic       past_zone;
   logic       wmode;
   logic [9:0] pos_abs;
   logic [3:0] wrd;
   logic [9:0] roff;
   logic [9:0] bstart;
   logic [9:0] rsz;
   logic [9:0] avail;
   logic [9:0] rem;
   logic [9:0] copy;
   logic [9:0] done_next;
   logic       cmd_last;

   always_comb begin
      blk_base  = {1'b0, blk_ff, 5'd0};
      past_zone = (blk_base + 10'd32) > {1'b0, zsz_ff};
      wmode     = wmode_ff | past_zone;
      pos_abs   = {1'b0, done_ff} + {1'b0, off_ff};
      // Entering word mode picks the word holding the next byte to copy.
      if (wmode_ff) begin
         wrd = word_ff;
      end else if (past_zone) begin
         wrd = {1'b0, pos_abs[4:2]};
      end else begin
         wrd = 4'd0;
      end
      roff      = blk_base + {4'd0, wrd, 2'd0};
      bstart    = (roff < {1'b0, off_ff}) ? ({1'b0, off_ff} - roff) : 10'd0;
      rsz       = wmode ? 10'd4 : 10'd32;
      avail     = (bstart < rsz) ? (rsz - bstart) : 10'd0;
      rem       = {1'b0, len_ff} - {1'b0, done_ff};
      copy      = (rem < avail) ? rem : avail;
      done_next = {1'b0, done_ff} + copy;
      cmd_last  = (done_next >= {1'b0, len_ff}) || (cnt_ff == CNT_W'(RESULT_CAP - 1));
   end

   assign stat.reject = (req_status != ST_OK) || (req_data.byte_count == 9'd0);
   assign stat.last   = cmd_last;

   always_comb begin
      off_in       = off_ff;
      len_in       = len_ff;
      zsz_in       = zsz_ff;
      status_in    = status_ff;
      blk_in       = blk_ff;
      word_in      = word_ff;
      done_in      = done_ff;
      wmode_in     = wmode_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.load) begin
         off_in    = req_data.start_offset;
         len_in    = req_data.byte_count;
         zsz_in    = zsz_sat;
         status_in = req_status;
         blk_in    = req_data.start_offset[8:5];
         word_in   = 4'd0;
         done_in   = 9'd0;
         wmode_in  = 1'b0;
         cnt_in    = '0;
      end
      if (cmd.report) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = status_ff;
         rsp_in.last   = 1'b1;
      end
      if (cmd.split) begin
         rsp_valid_in           = 1'b1;
         rsp_in.status          = ST_OK;
         rsp_in.issue_read      = 1'b1;
         rsp_in.block_index     = blk_ff;
         rsp_in.word_index      = wmode ? wrd[2:0] : 3'd0;
         rsp_in.read_full_block = !wmode;
         rsp_in.buffer_start    = bstart[4:0];
         rsp_in.copy_bytes      = copy[5:0];
         rsp_in.dest_index      = done_ff;
         rsp_in.last            = cmd_last;
         done_in                = done_next[8:0];
         wmode_in               = wmode;
         cnt_in                 = cnt_ff + 1'b1;
         if (wmode) begin
            word_in = wrd + 4'd1;
         end else begin
            blk_in = blk_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff    <= off_in;
      len_ff    <= len_in;
      zsz_ff    <= zsz_in;
      status_ff <= status_in;
      blk_ff    <= blk_in;
      word_ff   <= word_in;
      done_ff   <= done_in;
      wmode_ff  <= wmode_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== src/zone_read_chunk_splitter.sv =====
// ----------------------------------------------------------------------------
// zone_read_chunk_splitter
// Checks a zoned byte-range read request and splits it into 32-byte block and
// 4-byte word read commands, or reports a single status word.
// ----------------------------------------------------------------------------
// The first result word follows start through the controller state register and
// the registered result word. Throughput: one result word per cycle from the
// split sequencer, up to 20 per request; no new start is taken while busy.
// busy drops in the cycle the last word is shown; a new start is taken then.
// Reset (synchronous, active high) returns to idle and clears the lock bit.
// ----------------------------------------------------------------------------
`default_nettype none

module zone_read_chunk_splitter #(
   parameter int MAX_BYTES = zrcs_pkg::MAX_BYTES_DEF,
   parameter int MAX_SLOT  = zrcs_pkg::MAX_SLOT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire zrcs_pkg::req_type req_data,
   output logic                   rsp_valid,
   output zrcs_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);
   import zrcs_pkg::*;

   logic        locked;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   zrcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .locked  (locked)
   );

   zrcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   zrcs_dp #(
      .MAX_BYTES (MAX_BYTES),
      .MAX_SLOT  (MAX_SLOT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .locked    (locked),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/zrcs_chk.sv =====
// ----------------------------------------------------------------------------
// zrcs_chk
// Port-level checks on the request/result sequencing of the splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module zrcs_chk (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire zrcs_pkg::rsp_type rsp_data
);
   import zrcs_pkg::*;

   // A taken request keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a request was taken");

   // A word that is not the last of its request means the run is still going.
   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("busy low in the middle of a command run");

   // The next request needs a cycle of its own, so no word follows a last one.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result word directly after a last word");

   // An error status is always a single status-only word.
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> !rsp_data.issue_read && rsp_data.last)
      else $error("error status on a read command or a non-final word");

   // Every read command moves at least one byte and at most one block.
   a_copy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.issue_read |->
         rsp_data.copy_bytes != 6'd0 && rsp_data.copy_bytes <= 6'd32)
      else $error("read command copy length out of range");

endmodule

bind zone_read_chunk_splitter zrcs_chk u_zrcs_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zone read chunk splitter. Read requests go in
// through the start/busy port, and the lock bit is set over the APB port while
// the block is idle. Every result word is compared against a bench-side
// splitter that tracks the lock bit, or against the status of a directed row.
// A directed table covers rejects, zero length, zone-size saturation and the
// block-to-word switch. Random requests follow in three phases with different
// sender idling.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import zrcs_pkg::*;

   localparam int unsigned BLOCK_BYTES = 32;
   localparam int unsigned WORD_BYTES  = 4;
   // The longest correct quiet stretch is a lock write plus readback, or a
   // random sender gap. Either one is far below this limit.
   localparam int WATCHDOG_LIMIT = 500;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PHASE_ITEMS    = 32;
   localparam bit CHECK_TYPED    = 1'b1;
   localparam bit CHECK_PRED     = 1'b0;

   typedef struct {
      req_type    req;
      bit         lock;
      bit         typed;
      logic [2:0] status;
   } plan_row_type;

   logic        clock;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   req_type     req_data = '0;
   logic        psel     = 1'b0;
   logic        penable  = 1'b0;
   logic        pwrite   = 1'b0;
   logic [2:0]  paddr    = '0;
   logic [31:0] pwdata   = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;

   rsp_type      pending_words[$];
   plan_row_type plan[$];
   bit           lock_bit = 1'b0;
   int           idle_pct = 0;
   int           error_count = 0;
   int           words_checked = 0;
   int           requests_sent = 0;
   int           quiet_cycles = 0;

   zone_read_chunk_splitter DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void flag_error(string msg);
      if (error_count < 10) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
      error_count++;
   endfunction

   function automatic string fmt_word(rsp_type w);
      return $sformatf("st=%0d rd=%0d blk=%0d wd=%0d full=%0d bs=%0d cp=%0d dst=%0d last=%0d",
                       w.status, w.issue_read, w.block_index, w.word_index,
                       w.read_full_block, w.buffer_start, w.copy_bytes,
                       w.dest_index, w.last);
   endfunction

   function automatic string diff_fields(rsp_type want, rsp_type got);
      string s;
      s = "";
      if (got.status !== want.status) s = {s, " status"};
      if (got.issue_read !== want.issue_read) s = {s, " issue_read"};
      if (got.block_index !== want.block_index) s = {s, " block_index"};
      if (got.word_index !== want.word_index) s = {s, " word_index"};
      if (got.read_full_block !== want.read_full_block) s = {s, " read_full_block"};
      if (got.buffer_start !== want.buffer_start) s = {s, " buffer_start"};
      if (got.copy_bytes !== want.copy_bytes) s = {s, " copy_bytes"};
      if (got.dest_index !== want.dest_index) s = {s, " dest_index"};
      if (got.last !== want.last) s = {s, " last"};
      return s;
   endfunction

   function automatic rsp_type status_word(logic [2:0] st);
      rsp_type w;
      w = '0;
      w.status = st;
      w.last = 1'b1;
      return w;
   endfunction

   // Checks one request and queues its status word or the command words it splits into.
   function automatic void predict_split(req_type r);
      logic [2:0]  st;
      int unsigned zone, slot, off, len, zsz;
      int unsigned blk, wrd, done, rsz, roff, bstart, avail, rem, cpy;
      bit          word_mode;
      int          n;
      rsp_type     w;
      zone = r.zone;
      slot = r.slot;
      off = r.start_offset;
      len = r.byte_count;
      zsz = r.zone_bytes;
      st = ST_OK;
      n = 0;
      if (zone == ZONE_INVALID) st = ST_BAD_ZONE;
      else if (zone == ZONE_DATA && slot > MAX_SLOT_DEF) st = ST_BAD_SLOT;
      else if (len > MAX_BYTES_DEF || off > MAX_BYTES_DEF) st = ST_TOO_LARGE;
      else if ((zone == ZONE_OTP || zone == ZONE_DATA) && !lock_bit) st = ST_NOT_LOCKED;
      else if (len != 0) begin
         if (zsz > MAX_BYTES_DEF) zsz = MAX_BYTES_DEF;
         if (off + len > zsz) st = ST_PAST_END;
      end
      if (st != ST_OK || len == 0) begin
         pending_words.push_back(status_word(st));
         return;
      end
      blk = off / BLOCK_BYTES;
      wrd = 0;
      done = 0;
      word_mode = 1'b0;
      while (done < len && n < RESULT_CAP) begin
         // The first block that would run past the zone end switches the rest
         // of the request to word reads, starting at the word holding the
         // next wanted byte.
         if (!word_mode && blk * BLOCK_BYTES + BLOCK_BYTES > zsz) begin
            word_mode = 1'b1;
            wrd = ((done + off) / WORD_BYTES) % (BLOCK_BYTES / WORD_BYTES);
         end
         rsz = word_mode ? WORD_BYTES : BLOCK_BYTES;
         roff = blk * BLOCK_BYTES + wrd * WORD_BYTES;
         bstart = (roff < off) ? off - roff : 0;
         avail = (bstart < rsz) ? rsz - bstart : 0;
         rem = len - done;
         cpy = (rem < avail) ? rem : avail;
         w = '0;
         w.status = ST_OK;
         w.issue_read = 1'b1;
         w.block_index = 4'(blk);
         w.word_index = word_mode ? 3'(wrd) : 3'd0;
         w.read_full_block = !word_mode;
         w.buffer_start = 5'(bstart);
         w.copy_bytes = 6'(cpy);
         w.dest_index = 9'(done);
         w.last = (done + cpy >= len || n == RESULT_CAP - 1);
         pending_words.push_back(w);
         n++;
         done += cpy;
         if (word_mode) wrd = (wrd + 1) & 15;
         else blk = (blk + 1) & 15;
      end
   endfunction

   function automatic void add_row(logic [1:0] zone, int slot, int off, int len,
                                   int zsz, bit lock, bit typed, logic [2:0] st);
      plan_row_type row;
      row.req.zone = zone;
      row.req.slot = 5'(slot);
      row.req.start_offset = 9'(off);
      row.req.byte_count = 9'(len);
      row.req.zone_bytes = 9'(zsz);
      row.lock = lock;
      row.typed = typed;
      row.status = st;
      plan.push_back(row);
   endfunction

   // Mostly well-formed requests that fit their zone, some past the end, and
   // a share of fully random words.
   function automatic req_type random_request();
      req_type     r;
      int unsigned eff, off, sel;
      sel = $urandom_range(99);
      if (sel < 20) begin
         r.zone = 2'($urandom_range(3));
         r.slot = 5'($urandom_range(31));
         r.start_offset = 9'($urandom_range(511));
         r.byte_count = 9'($urandom_range(511));
         r.zone_bytes = 9'($urandom_range(511));
         return r;
      end
      if (lock_bit) r.zone = 2'($urandom_range(2));
      else r.zone = ($urandom_range(3) == 0) ? 2'($urandom_range(1, 2)) : ZONE_CONFIG;
      r.slot = 5'($urandom_range(MAX_SLOT_DEF));
      case ($urandom_range(19))
         0: r.zone_bytes = 9'($urandom_range(MAX_BYTES_DEF + 1, 511));
         1, 2, 3: r.zone_bytes = 9'($urandom_range(129, MAX_BYTES_DEF));
         default: r.zone_bytes = 9'($urandom_range(1, 128));
      endcase
      eff = (r.zone_bytes > MAX_BYTES_DEF) ? MAX_BYTES_DEF : r.zone_bytes;
      off = $urandom_range(eff - 1);
      r.start_offset = 9'(off);
      if (sel < 30) r.byte_count = 9'(eff - off + $urandom_range(1, 8));
      else r.byte_count = 9'($urandom_range(1, eff - off));
      return r;
   endfunction

   task automatic send_request(req_type r, bit typed, logic [2:0] st);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (typed) pending_words.push_back(status_word(st));
      else predict_split(r);
      requests_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_lock(bit val);
      wait_drained();
      repeat (2) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_LOCK, 2'b00};
      pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      lock_bit = val;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== val) begin
         flag_error($sformatf("lock readback: want %0d got %0d", val, prdata[0]));
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result checker and watchdog.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR @%0t: watchdog expired, %0d words outstanding",
                     $realtime, pending_words.size());
            $display("Simulation FAILED");
            $finish;
         end else if (rsp_valid) begin
            if (pending_words.size() == 0) begin
               flag_error({"unexpected word: ", fmt_word(rsp_data)});
            end else begin
               want = pending_words.pop_front();
               if (rsp_data !== want) begin
                  flag_error({"field mismatch:", diff_fields(want, rsp_data),
                              "\n   want ", fmt_word(want), "\n   got  ", fmt_word(rsp_data)});
               end
               words_checked++;
            end
         end
      end
   end

   initial begin
      int n_directed;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first rows run with the lock bit at its reset value.
      add_row(ZONE_OTP, 0, 0, 4, 64, 1'b0, CHECK_TYPED, ST_NOT_LOCKED);
      add_row(ZONE_DATA, 3, 0, 8, 64, 1'b0, CHECK_TYPED, ST_NOT_LOCKED);
      add_row(ZONE_CONFIG, 0, 0, 32, 128, 1'b0, CHECK_PRED, ST_OK);
      add_row(ZONE_INVALID, 31, 511, 511, 511, 1'b0, CHECK_TYPED, ST_BAD_ZONE);
      add_row(ZONE_DATA, 16, 0, 4, 64, 1'b0, CHECK_TYPED, ST_BAD_SLOT);
      add_row(ZONE_DATA, 31, 511, 511, 0, 1'b0, CHECK_TYPED, ST_BAD_SLOT);
      add_row(ZONE_CONFIG, 31, 0, 10, 64, 1'b0, CHECK_PRED, ST_OK);
      add_row(ZONE_CONFIG, 0, 0, 417, 416, 1'b0, CHECK_TYPED, ST_TOO_LARGE);
      add_row(ZONE_CONFIG, 0, 417, 1, 416, 1'b0, CHECK_TYPED, ST_TOO_LARGE);
      add_row(ZONE_CONFIG, 0, 511, 511, 511, 1'b0, CHECK_TYPED, ST_TOO_LARGE);
      add_row(ZONE_OTP, 0, 0, 417, 416, 1'b0, CHECK_TYPED, ST_TOO_LARGE);
      add_row(ZONE_CONFIG, 0, 400, 0, 0, 1'b0, CHECK_TYPED, ST_OK);
      add_row(ZONE_CONFIG, 0, 60, 10, 64, 1'b0, CHECK_TYPED, ST_PAST_END);
      add_row(ZONE_OTP, 0, 0, 64, 64, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_DATA, 15, 0, 416, 416, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_DATA, 0, 5, 411, 416, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_CONFIG, 0, 0, 416, 511, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_OTP, 0, 416, 1, 511, 1'b1, CHECK_TYPED, ST_PAST_END);
      add_row(ZONE_CONFIG, 0, 416, 0, 416, 1'b1, CHECK_TYPED, ST_OK);
      add_row(ZONE_OTP, 0, 17, 3, 20, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_CONFIG, 0, 0, 88, 88, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_DATA, 7, 33, 1, 64, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_OTP, 0, 3, 1, 4, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_CONFIG, 0, 1, 415, 416, 1'b1, CHECK_PRED, ST_OK);
      add_row(ZONE_DATA, 15, 0, 1, 511, 1'b1, CHECK_PRED, ST_OK);
      n_directed = plan.size();

      foreach (plan[i]) begin
         if (plan[i].lock != lock_bit) write_lock(plan[i].lock);
         send_request(plan[i].req, plan[i].typed, plan[i].status);
      end

      for (int phase = 0; phase < 3; phase++) begin
         write_lock(phase != 1);
         idle_pct = (phase == 0) ? 27 : (phase == 1) ? 51 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Let the block run dry once per phase before carrying on.
            if (i == PHASE_ITEMS / 2) wait_drained();
            send_request(random_request(), CHECK_PRED, ST_OK);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d read requests (%0d from the directed table) with the lock bit",
               requests_sent, n_directed);
      $display("in both states; %0d result words checked, %0d errors.",
               words_checked, error_count);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
